// File: src/rpn_pkg.sv
`default_nettype none

package rpn_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int DEPTH_W = 5;

    // op codes
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OP_W-1:0] OP_POP  = 3'd5;

    // value read from an empty stack
    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic [DEPTH_W-1:0]       depth;
        logic                     underflow;
        logic                     overflow;
        logic                     divide_by_zero;
    } out_t;

endpackage

`default_nettype wire

// File: src/rpn_stack_calculator.sv
`default_nettype none

// Reverse Polish calculator on a fixed stack of STACK_DEPTH signed 32-bit
// entries. Each request carries an op and a value: push stores the value,
// add/sub/mul/div pop a (top) then b and push b op a (wrapping arithmetic,
// division truncating toward zero), pop removes and reports the top. Every
// request gives exactly one result with the value pushed or popped, the
// stack depth afterwards (modulo 32) and underflow, overflow and
// divide-by-zero flags. Popping an empty stack yields -1 and flags underflow;
// a push onto a full stack is dropped and flagged; a zero divisor gives 0.
// Ops 6 and 7 change nothing and return a zero result with clear flags.
// Requests are taken one at a time: s_ready is high only while the
// sequencer is idle, and a new request may be taken while the previous
// result still waits on m_ready. The stack is a single-port memory read
// one entry per cycle, and all arithmetic runs on one shared 33-bit adder:
// multiply is 32 shift-add steps, divide is 32 restoring steps plus sign
// fixing.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire rpn_pkg::in_t s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output rpn_pkg::out_t     m_data
);
    import rpn_pkg::*;

    localparam int AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW     = $clog2(STACK_DEPTH + 1);
    localparam int ITER_W = $clog2(DATA_W);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POP_A = 4'd1;  // read top
    localparam logic [3:0] S_POP_B = 4'd2;  // capture a, read next
    localparam logic [3:0] S_GET_B = 4'd3;  // capture b, set up the op
    localparam logic [3:0] S_GET_P = 4'd4;  // capture popped value for pop op
    localparam logic [3:0] S_DIV_A = 4'd5;  // magnitude of divisor
    localparam logic [3:0] S_DIV_B = 4'd6;  // magnitude of dividend
    localparam logic [3:0] S_EXEC  = 4'd7;  // add/sub once, mul/div 32 steps
    localparam logic [3:0] S_DIV_N = 4'd8;  // quotient sign fix
    localparam logic [3:0] S_FIN   = 4'd9;  // push back and hand over the result

    // stack memory, single port
    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;

    // control state
    logic [3:0]        state_reg, state_next;
    logic [PW-1:0]     sp_reg, sp_next;
    logic              m_valid_reg, m_valid_next;

    // working registers
    logic [OP_W-1:0]   op_reg, op_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              empty_reg, empty_next;
    logic              under_reg, under_next;
    logic              dz_reg, dz_next;
    logic              push_reg, push_next;
    out_t              m_data_reg, m_data_next;

    // shared adder
    logic [DATA_W-1:0] add_x;
    logic [DATA_W-1:0] add_y;
    logic              add_sub;
    logic [DATA_W:0]   add_sum;

    // helpers
    logic [PW-1:0]     sp_dec;
    logic              sp_empty;
    logic              room;
    logic [DATA_W-1:0] popped;
    logic [DATA_W-1:0] rem_sh;
    logic              out_free;
    logic              pop_issue;
    logic              last_iter;

    assign sp_dec    = sp_reg - PW'(1);
    assign sp_empty  = (sp_reg == '0);
    assign room      = (sp_reg < PW'(STACK_DEPTH));
    assign popped    = empty_reg ? EMPTY_VALUE : rd_data_reg;
    assign rem_sh    = {acc_reg[DATA_W-2:0], b_reg[DATA_W-1]};
    assign out_free  = !m_valid_reg || m_ready;
    assign pop_issue = (state_reg == S_POP_A) || (state_reg == S_POP_B);
    assign last_iter = (cnt_reg == '1);
    assign rd_addr   = sp_dec[AW-1:0];
    assign wr_addr   = sp_reg[AW-1:0];

    // operand selection for the adder
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (state_reg)
            S_EXEC: begin
                case (op_reg)
                    OP_ADD: begin
                        add_x = b_reg;
                        add_y = a_reg;
                    end
                    OP_SUB: begin
                        add_x   = b_reg;
                        add_y   = a_reg;
                        add_sub = 1'b1;
                    end
                    OP_MUL: begin
                        add_x = acc_reg;
                        add_y = a_reg[0] ? b_reg : '0;
                    end
                    OP_DIV: begin
                        // trial subtract of divisor from shifted remainder
                        add_x   = rem_sh;
                        add_y   = a_reg;
                        add_sub = 1'b1;
                    end
                    default: begin
                        add_x = '0;
                    end
                endcase
            end
            S_DIV_A: begin
                add_y   = a_reg;
                add_sub = 1'b1;
            end
            S_DIV_B, S_DIV_N: begin
                add_y   = b_reg;
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(DATA_W + 1){add_sub}})
                   + (DATA_W + 1)'(add_sub);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        sp_next      = sp_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        empty_next   = empty_reg;
        under_next   = under_reg;
        dz_next      = dz_reg;
        push_next    = push_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // a pop on an empty stack leaves the pointer and yields -1
        if (pop_issue) begin
            if (sp_empty) begin
                empty_next = 1'b1;
                under_next = 1'b1;
            end else begin
                empty_next = 1'b0;
                mem_re     = 1'b1;
                sp_next    = sp_dec;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.op;
                    under_next = 1'b0;
                    dz_next    = 1'b0;
                    res_next   = '0;
                    push_next  = 1'b0;
                    if (s_data.op == OP_PUSH) begin
                        res_next   = s_data.value;
                        push_next  = 1'b1;
                        state_next = S_FIN;
                    end else if (s_data.op inside {[OP_ADD:OP_DIV]}) begin
                        push_next  = 1'b1;
                        state_next = S_POP_A;
                    end else if (s_data.op == OP_POP) begin
                        state_next = S_POP_A;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_POP_A: begin
                state_next = (op_reg == OP_POP) ? S_GET_P : S_POP_B;
            end
            S_POP_B: begin
                a_next     = popped;
                state_next = S_GET_B;
            end
            S_GET_B: begin
                b_next   = popped;
                acc_next = '0;
                cnt_next = '0;
                if (op_reg == OP_DIV) begin
                    neg_next = a_reg[DATA_W-1] ^ popped[DATA_W-1];
                    if (a_reg == '0) begin
                        res_next   = '0;
                        dz_next    = 1'b1;
                        state_next = S_FIN;
                    end else begin
                        state_next = S_DIV_A;
                    end
                end else begin
                    state_next = S_EXEC;
                end
            end
            S_GET_P: begin
                res_next   = popped;
                state_next = S_FIN;
            end
            S_DIV_A: begin
                if (a_reg[DATA_W-1]) begin
                    a_next = add_sum[DATA_W-1:0];
                end
                state_next = S_DIV_B;
            end
            S_DIV_B: begin
                if (b_reg[DATA_W-1]) begin
                    b_next = add_sum[DATA_W-1:0];
                end
                state_next = S_EXEC;
            end
            S_EXEC: begin
                case (op_reg)
                    OP_ADD, OP_SUB: begin
                        res_next   = add_sum[DATA_W-1:0];
                        state_next = S_FIN;
                    end
                    OP_MUL: begin
                        acc_next = add_sum[DATA_W-1:0];
                        a_next   = a_reg >> 1;
                        b_next   = b_reg << 1;
                        cnt_next = cnt_reg + ITER_W'(1);
                        if (last_iter) begin
                            res_next   = add_sum[DATA_W-1:0];
                            state_next = S_FIN;
                        end
                    end
                    OP_DIV: begin
                        // restoring step, quotient bits shift into b
                        acc_next = add_sum[DATA_W] ? rem_sh : add_sum[DATA_W-1:0];
                        b_next   = {b_reg[DATA_W-2:0], !add_sum[DATA_W]};
                        cnt_next = cnt_reg + ITER_W'(1);
                        if (last_iter) begin
                            state_next = S_DIV_N;
                        end
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_DIV_N: begin
                res_next   = neg_reg ? add_sum[DATA_W-1:0] : b_reg;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.result          = res_reg;
                    m_data_next.underflow       = under_reg;
                    m_data_next.divide_by_zero  = dz_reg;
                    m_data_next.overflow        = push_reg && !room;
                    m_data_next.depth           = DEPTH_W'(sp_reg);
                    if (push_reg && room) begin
                        mem_we                = 1'b1;
                        sp_next               = sp_reg + PW'(1);
                        m_data_next.depth     = DEPTH_W'(sp_reg + PW'(1));
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // stack memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= res_reg;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working and output registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        empty_reg  <= empty_next;
        under_reg  <= under_next;
        dz_reg     <= dz_next;
        push_reg   <= push_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
